### sv/scene_hierarchy_transform_propagate_defines.svh
// Assertion macros shared by the transform propagation block.
`ifndef SCENE_HIERARCHY_TRANSFORM_PROPAGATE_DEFINES_SVH
`define SCENE_HIERARCHY_TRANSFORM_PROPAGATE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SHTP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shtp assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SHTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shtp assertion failed");

`endif

### sv/shtp_pkg.sv
`default_nettype none
package shtp_pkg;

  localparam int BATCH_DEPTH = 1024;
  localparam int ADDR_W = $clog2(BATCH_DEPTH);
  localparam int CMP_W = 17;
  localparam logic [15:0] NO_MESH_CODE = 16'hFFFF;
  localparam logic [15:0] Q_ONE = 16'h4000;
  localparam logic [15:0] S_ONE = 16'h0100;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_CRS, ST_FIN} state_t;

  typedef enum logic {REG_MESH_BASE, REG_MAT_BASE} reg_idx_t;

  typedef struct packed {
    logic [15:0] mesh_base;
    logic [15:0] mat_base;
  } cfg_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [63:0] rot;
    logic [15:0] scale;
  } xform_t;

  typedef struct packed {
    logic       lookup;
    logic [9:0] parent_offset;
    logic       commit;
    logic       last;
  } store_req_t;

endpackage
`default_nettype wire

### sv/shtp_ifs.sv
`default_nettype none
interface shtp_node_if;
  logic        valid;
  logic        ready;
  logic [9:0]  parent_offset;
  logic [31:0] local_pos_x;
  logic [31:0] local_pos_y;
  logic [31:0] local_pos_z;
  logic [63:0] local_rotation;
  logic [15:0] local_scale;
  logic [15:0] local_mesh_index;
  logic [15:0] mesh_instance_index;
  logic [15:0] local_material_index;
  logic        last_in_batch;
  modport source (output valid, parent_offset, local_pos_x, local_pos_y, local_pos_z,
                  local_rotation, local_scale, local_mesh_index, mesh_instance_index,
                  local_material_index, last_in_batch, input ready);
  modport sink (input valid, parent_offset, local_pos_x, local_pos_y, local_pos_z,
                local_rotation, local_scale, local_mesh_index, mesh_instance_index,
                local_material_index, last_in_batch, output ready);
endinterface

interface shtp_result_if;
  logic        valid;
  logic        ready;
  logic        has_mesh;
  logic [16:0] global_mesh_index;
  logic [15:0] instance_slot;
  logic [16:0] global_material_index;
  logic [31:0] world_pos_x;
  logic [31:0] world_pos_y;
  logic [31:0] world_pos_z;
  logic [63:0] world_rotation;
  logic [15:0] world_scale;
  logic        batch_end;
  modport source (output valid, has_mesh, global_mesh_index, instance_slot,
                  global_material_index, world_pos_x, world_pos_y, world_pos_z,
                  world_rotation, world_scale, batch_end, input ready);
  modport sink (input valid, has_mesh, global_mesh_index, instance_slot,
                global_material_index, world_pos_x, world_pos_y, world_pos_z,
                world_rotation, world_scale, batch_end, output ready);
endinterface
`default_nettype wire

### sv/shtp_cfg.sv
`default_nettype none
module shtp_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output shtp_pkg::cfg_t     cfg
);

  shtp_pkg::reg_idx_t idx;
  logic wr;

  assign pready = 1'b1;
  assign idx = shtp_pkg::reg_idx_t'(paddr[2]);
  assign wr = psel && penable && pwrite;

  // write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        shtp_pkg::REG_MESH_BASE: cfg.mesh_base <= pwdata[15:0];
        shtp_pkg::REG_MAT_BASE:  cfg.mat_base <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      shtp_pkg::REG_MESH_BASE: prdata = {16'h0, cfg.mesh_base};
      shtp_pkg::REG_MAT_BASE:  prdata = {16'h0, cfg.mat_base};
      default:                 prdata = 32'h0;
    endcase
  end

endmodule
`default_nettype wire

### sv/shtp_store.sv
`default_nettype none
module shtp_store (
  input  logic                  clk,
  input  logic                  rst,
  input  shtp_pkg::store_req_t  req,
  input  shtp_pkg::xform_t      wdata,
  output shtp_pkg::xform_t      parent
);

  shtp_pkg::xform_t mem [shtp_pkg::BATCH_DEPTH];
  shtp_pkg::xform_t rdata;
  logic [shtp_pkg::ADDR_W-1:0] pos;
  logic [shtp_pkg::CMP_W-1:0]  pos_w;
  logic [shtp_pkg::CMP_W-1:0]  off_w;
  logic [shtp_pkg::CMP_W-1:0]  diff_w;
  logic                        par_ok;
  logic                        par_hit;

  assign pos_w = shtp_pkg::CMP_W'(pos);
  assign off_w = shtp_pkg::CMP_W'(req.parent_offset);
  assign diff_w = pos_w - off_w;
  assign par_hit = (req.parent_offset != 10'd0) && (off_w <= pos_w);

  // read parent entry
  always_ff @(posedge clk) begin
    if (req.lookup) begin
      rdata <= mem[diff_w[shtp_pkg::ADDR_W-1:0]];
    end
  end

  // write result at the batch position
  always_ff @(posedge clk) begin
    if (req.commit) begin
      mem[pos] <= wdata;
    end
  end

  // track parent hit and batch position
  always_ff @(posedge clk) begin
    if (rst) begin
      par_ok <= 1'b0;
      pos    <= '0;
    end else begin
      if (req.lookup) begin
        par_ok <= par_hit;
      end
      if (req.commit) begin
        if (req.last || (pos_w == shtp_pkg::CMP_W'(shtp_pkg::BATCH_DEPTH - 1))) begin
          pos <= '0;
        end else begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

  // substitute identity for a root
  always_comb begin
    if (par_ok) begin
      parent = rdata;
    end else begin
      parent.px    = 32'h0;
      parent.py    = 32'h0;
      parent.pz    = 32'h0;
      parent.rot   = {shtp_pkg::Q_ONE, 48'h0};
      parent.scale = shtp_pkg::S_ONE;
    end
  end

endmodule
`default_nettype wire

### sv/shtp_core.sv
`default_nettype none
`include "scene_hierarchy_transform_propagate_defines.svh"
module shtp_core (
  input  logic                  clk,
  input  logic                  rst,
  input  shtp_pkg::cfg_t        cfg,
  shtp_node_if.sink             node,
  shtp_result_if.source         result,
  output shtp_pkg::store_req_t  req,
  output shtp_pkg::xform_t      wdata,
  input  shtp_pkg::xform_t      parent
);

  shtp_pkg::state_t state, state_next;
  logic accept, fin_go;

  // item registers
  logic signed [31:0] lp [3];
  logic [63:0] lq;
  logic [15:0] ls, lmesh, linst, lmat;
  logic        llast;

  // stage registers
  logic signed [31:0] pp [3];
  logic signed [15:0] pq [4];
  logic signed [31:0] slp [3];
  logic [63:0]        wq;
  logic [15:0]        ws;
  logic signed [35:0] t [3];
  logic               out_valid;

  function automatic logic [31:0] sat32(input logic signed [41:0] v);
    if (v > 42'sd2147483647) return 32'h7FFF_FFFF;
    else if (v < -42'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'h7FFF;
    else if (v < -20'sd32768) return 16'h8000;
    else return v[15:0];
  endfunction

  assign accept = node.valid && node.ready;
  assign fin_go = (state == shtp_pkg::ST_FIN) && (!out_valid || result.ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      shtp_pkg::ST_IDLE: if (accept) state_next = shtp_pkg::ST_MUL;
      shtp_pkg::ST_MUL:  state_next = shtp_pkg::ST_CRS;
      shtp_pkg::ST_CRS:  state_next = shtp_pkg::ST_FIN;
      shtp_pkg::ST_FIN:  if (fin_go) state_next = shtp_pkg::ST_IDLE;
      default:           state_next = shtp_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    node.ready        = (state == shtp_pkg::ST_IDLE);
    req.lookup        = accept;
    req.parent_offset = node.parent_offset;
    req.commit        = fin_go;
    req.last          = llast;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= shtp_pkg::ST_IDLE;
    else state <= state_next;
  end

  // capture input word
  always_ff @(posedge clk) begin
    if (accept) begin
      lp[0] <= node.local_pos_x;
      lp[1] <= node.local_pos_y;
      lp[2] <= node.local_pos_z;
      lq    <= node.local_rotation;
      ls    <= node.local_scale;
      lmesh <= node.local_mesh_index;
      linst <= node.mesh_instance_index;
      lmat  <= node.local_material_index;
      llast <= node.last_in_batch;
    end
  end

  // scale position, quaternion product, scale product
  logic signed [48:0] sprod [3];
  logic signed [15:0] pqc [4], lqc [4];
  logic signed [33:0] qs [4];
  logic signed [33:0] qr [4];
  logic [32:0]        sc;

  always_comb begin
    pqc[0] = parent.rot[63:48];
    pqc[1] = parent.rot[47:32];
    pqc[2] = parent.rot[31:16];
    pqc[3] = parent.rot[15:0];
    lqc[0] = lq[63:48];
    lqc[1] = lq[47:32];
    lqc[2] = lq[31:16];
    lqc[3] = lq[15:0];
    for (int i = 0; i < 3; i++) begin
      sprod[i] = (lp[i] * $signed({1'b0, parent.scale}) + 49'sd128) >>> 8;
    end
    qs[0] = 34'(pqc[0] * lqc[0]) - 34'(pqc[1] * lqc[1])
          - 34'(pqc[2] * lqc[2]) - 34'(pqc[3] * lqc[3]);
    qs[1] = 34'(pqc[0] * lqc[1]) + 34'(pqc[1] * lqc[0])
          + 34'(pqc[2] * lqc[3]) - 34'(pqc[3] * lqc[2]);
    qs[2] = 34'(pqc[0] * lqc[2]) - 34'(pqc[1] * lqc[3])
          + 34'(pqc[2] * lqc[0]) + 34'(pqc[3] * lqc[1]);
    qs[3] = 34'(pqc[0] * lqc[3]) + 34'(pqc[1] * lqc[2])
          - 34'(pqc[2] * lqc[1]) + 34'(pqc[3] * lqc[0]);
    for (int i = 0; i < 4; i++) begin
      qr[i] = (qs[i] + 34'sd8192) >>> 14;
    end
    sc = 33'(parent.scale * ls) + 33'd128;
  end

  always_ff @(posedge clk) begin
    if (state == shtp_pkg::ST_MUL) begin
      pp[0] <= parent.px;
      pp[1] <= parent.py;
      pp[2] <= parent.pz;
      for (int i = 0; i < 4; i++) pq[i] <= pqc[i];
      for (int i = 0; i < 3; i++) slp[i] <= sat32(42'($signed(sprod[i][40:0])));
      wq <= {sat16(qr[0][19:0]), sat16(qr[1][19:0]), sat16(qr[2][19:0]),
             sat16(qr[3][19:0])};
      ws <= (sc[32:24] != 9'd0) ? 16'hFFFF : sc[23:8];
    end
  end

  // first cross product
  logic signed [48:0] cc [3];
  logic signed [48:0] tr [3];

  always_comb begin
    cc[0] = 49'(pq[2] * slp[2]) - 49'(pq[3] * slp[1]);
    cc[1] = 49'(pq[3] * slp[0]) - 49'(pq[1] * slp[2]);
    cc[2] = 49'(pq[1] * slp[1]) - 49'(pq[2] * slp[0]);
    for (int i = 0; i < 3; i++) tr[i] = (cc[i] + 49'sd4096) >>> 13;
  end

  always_ff @(posedge clk) begin
    if (state == shtp_pkg::ST_CRS) begin
      for (int i = 0; i < 3; i++) t[i] <= tr[i][35:0];
    end
  end

  // second cross product and final sum
  logic signed [53:0] rs [3];
  logic signed [53:0] rr [3];
  logic signed [41:0] wp [3];
  logic [31:0]        wps [3];

  always_comb begin
    rs[0] = 54'(pq[0] * t[0]) + 54'(pq[2] * t[2]) - 54'(pq[3] * t[1]);
    rs[1] = 54'(pq[0] * t[1]) + 54'(pq[3] * t[0]) - 54'(pq[1] * t[2]);
    rs[2] = 54'(pq[0] * t[2]) + 54'(pq[1] * t[1]) - 54'(pq[2] * t[0]);
    for (int i = 0; i < 3; i++) begin
      rr[i]  = (rs[i] + 54'sd8192) >>> 14;
      wp[i]  = 42'(pp[i]) + 42'(slp[i]) + 42'($signed(rr[i][39:0]));
      wps[i] = sat32(wp[i]);
    end
    wdata.px    = wps[0];
    wdata.py    = wps[1];
    wdata.pz    = wps[2];
    wdata.rot   = wq;
    wdata.scale = ws;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (fin_go) begin
      if (lmesh != shtp_pkg::NO_MESH_CODE) begin
        result.has_mesh              <= 1'b1;
        result.global_mesh_index     <= 17'(cfg.mesh_base) + 17'(lmesh);
        result.instance_slot         <= linst;
        result.global_material_index <= 17'(cfg.mat_base) + 17'(lmat);
      end else begin
        result.has_mesh              <= 1'b0;
        result.global_mesh_index     <= 17'h0;
        result.instance_slot         <= 16'h0;
        result.global_material_index <= 17'h0;
      end
      result.world_pos_x    <= wps[0];
      result.world_pos_y    <= wps[1];
      result.world_pos_z    <= wps[2];
      result.world_rotation <= wq;
      result.world_scale    <= ws;
      result.batch_end      <= llast;
    end
  end

  `SHTP_ASSERT_NEXT(a_accept_to_mul, accept, state == shtp_pkg::ST_MUL)
  `SHTP_ASSERT_NEXT(a_stall_holds, (state == shtp_pkg::ST_FIN) && out_valid && !result.ready,
                    state == shtp_pkg::ST_FIN)
  `SHTP_ASSERT_NEXT(a_fin_loads_out, fin_go, out_valid && (state == shtp_pkg::ST_IDLE))
  `SHTP_ASSERT_NOW(a_no_accept_busy, state != shtp_pkg::ST_IDLE, !accept && !req.lookup)

endmodule
`default_nettype wire

### sv/scene_hierarchy_transform_propagate.sv
// The accepted input word passes through the MUL, CRS and FIN states to the output register.
// Nodes are taken only in IDLE, so each waits for the multiply sequence (scale and quaternion
// product, first cross product, second cross product) that follows the parent store read.
// A result waiting at the output stalls the final step; the next node cannot enter meanwhile.
// Reset (rst, synchronous): clears state, configuration, batch position and handshake state; the
// transform store is not cleared, entries are written before they are read within a batch.
`default_nettype none
module scene_hierarchy_transform_propagate (
  input  logic          clk,
  input  logic          rst,
  shtp_node_if.sink     node,
  shtp_result_if.source result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  shtp_pkg::cfg_t       cfg;
  shtp_pkg::store_req_t req;
  shtp_pkg::xform_t     wdata;
  shtp_pkg::xform_t     parent;

  shtp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  shtp_store u_store (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .wdata  (wdata),
    .parent (parent)
  );

  shtp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .node   (node),
    .result (result),
    .req    (req),
    .wdata  (wdata),
    .parent (parent)
  );

endmodule
`default_nettype wire
